### rtl/ppfl_pkg.sv
// shared constants and codes for the particle pool free list unit
package ppfl_pkg;

  localparam int POOL_SLOTS_DEF = 128;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 104;

endpackage

### rtl/ppfl_ram.sv
// single port write, single port registered read slot memory
module ppfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/particle_pool_free_list_unit.sv
// particle pool with lifo free list: create, tick and query over slot memories
// a tick walks every slot, one slot read per cycle into the adders, and ages each
// live slot, pushing expired ones onto the free list
// one word is in work at a time; the next is taken in the cycle after the result
// moves to the output register, which may still be waiting on out_tready
// reset: a clearing pass over all POOL_SLOTS slots rebuilds links and lifetimes, in_tready low
module particle_pool_free_list_unit
  import ppfl_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x[31:0] pos_y[63:32] vel_x[95:64] vel_y[127:96] life_ticks[143:128]
  // query_slot[150:144] zero[151]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // slot_index[6:0] slot_live[7] slot_x[39:8] slot_y[71:40] slot_frames[87:72]
  // freed_count[95:88] free_count[103:96]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]            out_tuser
);

  localparam int AW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CRE   = 3'd2;
  localparam logic [2:0] S_QRY   = 3'd3;
  localparam logic [2:0] S_TICK  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [1:0]  in_opcode;
  logic [31:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y;
  logic [15:0] in_life;
  logic [6:0]  in_query;

  assign in_opcode = in_tuser;
  assign in_pos_x  = in_tdata[31:0];
  assign in_pos_y  = in_tdata[63:32];
  assign in_vel_x  = in_tdata[95:64];
  assign in_vel_y  = in_tdata[127:96];
  assign in_life   = in_tdata[143:128];
  assign in_query  = in_tdata[150:144];

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] clr_idx_r, clr_idx_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          wb_valid_r, wb_valid_nxt;
  logic [AW-1:0] wb_idx_r, wb_idx_nxt;
  logic [CW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] free_total_r, free_total_nxt;
  logic [CW-1:0] freed_r, freed_nxt;
  logic          qok_r, qok_nxt;

  logic [6:0]  res_slot_r, res_slot_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic        res_live_r, res_live_nxt;
  logic [31:0] res_x_r, res_x_nxt;
  logic [31:0] res_y_r, res_y_nxt;
  logic [15:0] res_frames_r, res_frames_nxt;
  logic [7:0]  res_freed_r, res_freed_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]            out_user_r, out_user_nxt;

  // memory ports
  logic [AW-1:0] raddr, waddr;
  logic          fr_we, pos_we, vel_we, nf_we;
  logic [15:0]   fr_wdata, fr_rd;
  logic [31:0]   px_wdata, py_wdata, px_rd, py_rd, vx_rd, vy_rd;
  logic [CW-1:0] nf_wdata, nf_rd;

  logic          accept;
  logic [31:0]   q_ext, head_ext, freed_ext, total_ext;
  logic          q_in_range;
  logic          list_empty;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign q_ext      = 32'(in_query);
  assign head_ext   = 32'(free_head_r);
  assign freed_ext  = 32'(freed_r);
  assign total_ext  = 32'(free_total_r);
  assign q_in_range = q_ext < 32'(POOL_SLOTS);
  assign list_empty = (free_total_r == '0) || (free_head_r >= CW'(POOL_SLOTS));

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    wb_valid_nxt   = 1'b0;
    wb_idx_nxt     = wb_idx_r;
    free_head_nxt  = free_head_r;
    free_total_nxt = free_total_r;
    freed_nxt      = freed_r;
    qok_nxt        = qok_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    res_live_nxt   = res_live_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_frames_nxt = res_frames_r;
    res_freed_nxt  = res_freed_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    raddr    = free_head_r[AW-1:0];
    waddr    = free_head_r[AW-1:0];
    fr_we    = 1'b0;
    pos_we   = 1'b0;
    vel_we   = 1'b0;
    nf_we    = 1'b0;
    fr_wdata = in_life;
    px_wdata = in_pos_x;
    py_wdata = in_pos_y;
    nf_wdata = free_head_r;

    unique case (state_r)
      S_CLEAR: begin
        waddr    = clr_idx_r[AW-1:0];
        fr_we    = 1'b1;
        fr_wdata = '0;
        nf_we    = 1'b1;
        nf_wdata = clr_idx_r + CW'(1);
        clr_idx_nxt = clr_idx_r + CW'(1);
        if (clr_idx_r == CW'(POOL_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_opcode == OP_QUERY) begin
          raddr = q_ext[AW-1:0];
        end
        if (accept) begin
          res_slot_nxt   = '0;
          res_status_nxt = ST_OK;
          res_live_nxt   = 1'b0;
          res_x_nxt      = '0;
          res_y_nxt      = '0;
          res_frames_nxt = '0;
          res_freed_nxt  = '0;
          state_nxt      = S_FIN;
          priority if (in_opcode == OP_CREATE) begin
            if (in_life == '0) begin
              res_status_nxt = ST_ZERO;
            end else if (list_empty) begin
              res_status_nxt = ST_FULL;
            end else begin
              // load the head slot and fetch its link
              fr_we     = 1'b1;
              pos_we    = 1'b1;
              vel_we    = 1'b1;
              state_nxt = S_CRE;
            end
          end else if (in_opcode == OP_TICK) begin
            rd_idx_nxt = '0;
            freed_nxt  = '0;
            state_nxt  = S_TICK;
          end else if (in_opcode == OP_QUERY) begin
            res_slot_nxt = in_query;
            qok_nxt      = q_in_range;
            state_nxt    = S_QRY;
          end else begin
          end
        end
      end
      S_CRE: begin
        free_head_nxt  = nf_rd;
        free_total_nxt = free_total_r - CW'(1);
        res_slot_nxt   = head_ext[6:0];
        state_nxt      = S_FIN;
      end
      S_QRY: begin
        if (qok_r) begin
          res_live_nxt   = (fr_rd != '0);
          res_x_nxt      = px_rd;
          res_y_nxt      = py_rd;
          res_frames_nxt = fr_rd;
        end
        state_nxt = S_FIN;
      end
      S_TICK: begin
        // issue stage: read the next slot
        raddr = rd_idx_r[AW-1:0];
        if (rd_idx_r < CW'(POOL_SLOTS)) begin
          rd_idx_nxt   = rd_idx_r + CW'(1);
          wb_valid_nxt = 1'b1;
          wb_idx_nxt   = rd_idx_r[AW-1:0];
        end
        // write-back stage: age the slot read last cycle
        waddr    = wb_idx_r;
        fr_wdata = fr_rd - 16'd1;
        px_wdata = px_rd + vx_rd;
        py_wdata = py_rd + vy_rd;
        if (wb_valid_r && fr_rd != '0) begin
          fr_we  = 1'b1;
          pos_we = 1'b1;
          if (fr_rd == 16'd1) begin
            nf_we          = 1'b1;
            nf_wdata       = free_head_r;
            free_head_nxt  = CW'(wb_idx_r);
            free_total_nxt = free_total_r + CW'(1);
            freed_nxt      = freed_r + CW'(1);
          end
        end
        if (!wb_valid_r && rd_idx_r == CW'(POOL_SLOTS)) begin
          res_freed_nxt = freed_ext[7:0];
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {total_ext[7:0], res_freed_r, res_frames_r, res_y_r, res_x_r,
                           res_live_r, res_slot_r};
          out_user_nxt  = res_status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      rd_idx_r     <= '0;
      wb_valid_r   <= 1'b0;
      free_head_r  <= '0;
      free_total_r <= CW'(POOL_SLOTS);
      freed_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      rd_idx_r     <= rd_idx_nxt;
      wb_valid_r   <= wb_valid_nxt;
      free_head_r  <= free_head_nxt;
      free_total_r <= free_total_nxt;
      freed_r      <= freed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_idx_r     <= wb_idx_nxt;
    qok_r        <= qok_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    res_live_r   <= res_live_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    res_frames_r <= res_frames_nxt;
    res_freed_r  <= res_freed_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  ppfl_ram #(.WIDTH(16), .DEPTH(POOL_SLOTS), .AW(AW)) u_frames (
    .clk(clk), .we(fr_we), .waddr(waddr), .wdata(fr_wdata), .raddr(raddr), .rdata(fr_rd)
  );
  ppfl_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS), .AW(AW)) u_pos_x (
    .clk(clk), .we(pos_we), .waddr(waddr), .wdata(px_wdata), .raddr(raddr), .rdata(px_rd)
  );
  ppfl_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS), .AW(AW)) u_pos_y (
    .clk(clk), .we(pos_we), .waddr(waddr), .wdata(py_wdata), .raddr(raddr), .rdata(py_rd)
  );
  ppfl_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS), .AW(AW)) u_vel_x (
    .clk(clk), .we(vel_we), .waddr(waddr), .wdata(in_vel_x), .raddr(raddr), .rdata(vx_rd)
  );
  ppfl_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS), .AW(AW)) u_vel_y (
    .clk(clk), .we(vel_we), .waddr(waddr), .wdata(in_vel_y), .raddr(raddr), .rdata(vy_rd)
  );
  ppfl_ram #(.WIDTH(CW), .DEPTH(POOL_SLOTS), .AW(AW)) u_next_free (
    .clk(clk), .we(nf_we), .waddr(waddr), .wdata(nf_wdata), .raddr(raddr), .rdata(nf_rd)
  );

  // free list count never exceeds the pool
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= CW'(POOL_SLOTS))
    else $error("free count above pool size");

  // a completed pop takes exactly one slot off the list
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRE) |=> (free_total_r == $past(free_total_r) - CW'(1)))
    else $error("create did not decrement free count");

  // a slot expiring on tick is pushed and becomes the new head
  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && wb_valid_r && fr_rd == 16'd1)
      |=> (free_head_r == CW'($past(wb_idx_r))
           && free_total_r == $past(free_total_r) + CW'(1)))
    else $error("expired slot not pushed onto free list");

  // no write-back pending outside the tick walk
  a_wb_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    wb_valid_r |-> (state_r == S_TICK))
    else $error("write-back stage active outside tick");

endmodule

### test/tb.sv
// testbench for the particle pool free list unit: predicted reports checked field by field
module tb;
  import ppfl_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int SLOTS = POOL_SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = SLOTS + 60;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] px, py, vx, vy;
    logic [15:0] life;
    logic [6:0]  qslot;
    bit          pick_live_slot;
  } pool_word_t;

  typedef struct {
    logic [6:0]  slot;
    logic [1:0]  status;
    logic        live;
    logic [31:0] x, y;
    logic [15:0] frames;
    logic [7:0]  freed, free_cnt;
  } pool_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = OP_NOP;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  particle_pool_free_list_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted pool contents
  logic [15:0] frames_left [SLOTS];
  logic [31:0] pos_x [SLOTS];
  logic [31:0] pos_y [SLOTS];
  logic [31:0] vel_x [SLOTS];
  logic [31:0] vel_y [SLOTS];
  int          link [SLOTS];
  int          free_head;
  int          free_total;
  bit          ever_written [SLOTS];
  int          written_slots [$];

  pool_word_t   pending_words [$];
  pool_report_t expected_reports [$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  total_words = -1;
  int  reports_seen = 0;
  int  idle_cycles = 0;
  logic in_fire = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      frames_left[i] = '0;
      pos_x[i] = '0;
      pos_y[i] = '0;
      vel_x[i] = '0;
      vel_y[i] = '0;
      link[i] = i + 1;
      ever_written[i] = 1'b0;
    end
    free_head = 0;
    free_total = SLOTS;
  end

  task automatic predict_pool_op(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
    pool_report_t r;
    int s;
    logic [6:0] q;
    r.slot = '0;
    r.status = ST_OK;
    r.live = 1'b0;
    r.x = '0;
    r.y = '0;
    r.frames = '0;
    r.freed = '0;
    case (op)
      OP_CREATE: begin
        if (d[143:128] == 16'd0) begin
          r.status = ST_ZERO;
        end else if (free_total == 0) begin
          r.status = ST_FULL;
        end else begin
          s = free_head;
          free_head = link[s];
          free_total--;
          pos_x[s] = d[31:0];
          pos_y[s] = d[63:32];
          vel_x[s] = d[95:64];
          vel_y[s] = d[127:96];
          frames_left[s] = d[143:128];
          if (!ever_written[s]) begin
            ever_written[s] = 1'b1;
            written_slots.push_back(s);
          end
          r.slot = s[6:0];
        end
      end
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (frames_left[i] != 16'd0) begin
            frames_left[i] = frames_left[i] - 16'd1;
            pos_x[i] = pos_x[i] + vel_x[i];
            pos_y[i] = pos_y[i] + vel_y[i];
            // expired slot goes to the front of the free list
            if (frames_left[i] == 16'd0) begin
              link[i] = free_head;
              free_head = i;
              free_total++;
              r.freed = r.freed + 8'd1;
            end
          end
        end
      end
      OP_QUERY: begin
        q = d[150:144];
        r.slot = q;
        r.frames = frames_left[q];
        r.live = (frames_left[q] != 16'd0);
        r.x = pos_x[q];
        r.y = pos_y[q];
      end
      default: ;
    endcase
    r.free_cnt = free_total[7:0];
    expected_reports.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: outputs are checked before the new word is predicted
  always @(posedge clk) begin : monitor_proc
    pool_report_t r;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $error("report with no expectation waiting: tdata 0x%0h", out_tdata);
        mismatches++;
      end else begin
        r = expected_reports.pop_front();
        check_field("slot_index", 32'(r.slot), 32'(out_tdata[6:0]));
        check_field("status", 32'(r.status), 32'(out_tuser));
        check_field("slot_live", 32'(r.live), 32'(out_tdata[7]));
        check_field("slot_x", r.x, out_tdata[39:8]);
        check_field("slot_y", r.y, out_tdata[71:40]);
        check_field("slot_frames", 32'(r.frames), 32'(out_tdata[87:72]));
        check_field("freed_count", 32'(r.freed), 32'(out_tdata[95:88]));
        check_field("free_count", 32'(r.free_cnt), 32'(out_tdata[103:96]));
      end
    end
    if (rst_n && in_tvalid && in_tready)
      predict_pool_op(in_tuser, in_tdata);
  end

  // driver: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : driver_proc
    logic v;
    pool_word_t w;
    v = in_tvalid;
    if (in_fire) begin
      v = 1'b0;
      words_sent++;
    end
    if (rst_n && !v) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        // queries marked pick_live_slot ask for a slot that some create has filled
        if (w.pick_live_slot && written_slots.size() > 0)
          w.qslot = 7'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
        in_tdata <= {1'b0, w.qslot, w.life, w.vy, w.vx, w.py, w.px};
        in_tuser <= w.op;
        v = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
        end
      end
    end
    in_tvalid <= v;
  end

  // receiver: stall pattern changes every so often, plus long hold-offs
  int stall_mode = 0;
  int phase_left = 0;
  int hold_left = 0;
  int next_hold_at = 150;

  always @(negedge clk) begin : receiver_proc
    logic r;
    if (!rst_n) begin
      r = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      r = 1'b0;
    end else if (reports_seen >= next_hold_at) begin
      next_hold_at = next_hold_at + 350;
      hold_left = HOLD_CYCLES;
      r = 1'b0;
    end else begin
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 200);
      end else begin
        phase_left--;
      end
      case (stall_mode)
        0: r = 1'b1;
        1: r = 1'($urandom_range(0, 1));
        2: r = ($urandom_range(0, 3) == 0);
        default: r = ($urandom_range(0, 7) != 0);
      endcase
    end
    out_tready <= r;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_life();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 75) return 16'($urandom_range(1, 6));
    return 16'($urandom_range(7, 300));
  endfunction

  function automatic void queue_word(input logic [1:0] op, input logic [31:0] px,
                                     input logic [31:0] py, input logic [31:0] vx,
                                     input logic [31:0] vy, input logic [15:0] life,
                                     input logic [6:0] qslot, input bit pick);
    pool_word_t w;
    w.op = op;
    w.px = px;
    w.py = py;
    w.vx = vx;
    w.vy = vy;
    w.life = life;
    w.qslot = qslot;
    w.pick_live_slot = pick;
    pending_words.push_back(w);
  endfunction

  function automatic void queue_random(input logic [1:0] op, input logic [15:0] life,
                                       input logic [6:0] qslot, input bit pick);
    queue_word(op, rand_q16(), rand_q16(), rand_q16(), rand_q16(), life, qslot, pick);
  endfunction

  initial begin : stimulus_proc
    int n;
    int r;
    // extremes, wraps, lifo reuse, zero lifetime, no-op
    queue_word(OP_CREATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               16'd1, 7'h7F, 0);
    queue_word(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               16'hFFFF, 7'd0, 0);
    queue_word(OP_CREATE, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 16'd0, 7'd0, 0);
    queue_word(OP_CREATE, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF,
               16'hFFFF, 7'd0, 0);
    queue_word(OP_CREATE, 32'hFFFF_0000, 32'h0001_8000, 32'h0000_4000, 32'hFFFE_0000,
               16'd2, 7'd0, 0);
    queue_random(OP_TICK, 16'd0, 7'd0, 0);
    queue_random(OP_QUERY, 16'd0, 7'd0, 0);
    queue_random(OP_QUERY, 16'd0, 7'd1, 0);
    queue_random(OP_TICK, 16'd0, 7'd0, 0);
    queue_random(OP_QUERY, 16'd0, 7'd2, 0);
    queue_random(OP_CREATE, 16'd3, 7'd0, 0);
    queue_random(OP_CREATE, 16'd1, 7'd0, 0);
    queue_random(OP_CREATE, 16'h8000, 7'd0, 0);
    queue_random(OP_NOP, 16'd5, 7'd3, 0);
    queue_random(OP_QUERY, 16'd0, 7'd2, 0);
    queue_random(OP_QUERY, 16'd0, 7'd3, 0);
    queue_random(OP_TICK, 16'd0, 7'd0, 0);
    queue_random(OP_QUERY, 16'd0, 7'd0, 0);
    queue_random(OP_TICK, 16'd0, 7'd0, 0);
    queue_random(OP_NOP, 16'd0, 7'd0, 0);

    n = 0;
    while (n < 800) begin
      if (n == 200 || n == 550) begin
        // run the pool dry so creates come back full, with a zero lifetime among them
        for (int k = 0; k < 140; k++)
          queue_random(OP_CREATE, ($urandom_range(0, 9) == 0) ? 16'd0 :
                       16'($urandom_range(1, 40)), 7'($urandom), 0);
        n += 140;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45)
          queue_random(OP_CREATE, rand_life(), 7'($urandom), 0);
        else if (r < 70)
          queue_random(OP_TICK, 16'($urandom), 7'($urandom), 0);
        else if (r < 94)
          queue_random(OP_QUERY, 16'($urandom), 7'd0, 1);
        else
          queue_random(OP_NOP, 16'($urandom), 7'($urandom), 0);
        n++;
      end
    end
    total_words = pending_words.size();

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    wait (words_sent == total_words);
    wait (expected_reports.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
